// ----- hw/rtl/gfsa_pkg.sv -----
// ----------------------------------------------------------------------------
// gfsa_pkg: shared types and constants of the gap-fill segment aggregator
// Number format, operation codes, queue entry layout and state encodings.
// ----------------------------------------------------------------------------
package gfsa_pkg;

	localparam int VALUE_WIDTH     = 32;
	localparam int FRAC_BITS       = 16;
	localparam int TALLY_WIDTH     = 24;
	localparam int TOTAL_WIDTH     = 48;
	localparam int HALF_WIDTH      = TOTAL_WIDTH / 2;
	localparam int PROD_WIDTH      = HALF_WIDTH + VALUE_WIDTH;
	localparam int FULL_WIDTH      = TOTAL_WIDTH + VALUE_WIDTH;
	localparam int SHIFT_WIDTH     = FULL_WIDTH - FRAC_BITS;
	localparam int QUEUE_DEPTH     = 2;
	localparam int APB_ADDR_WIDTH  = 3;
	localparam int APB_DATA_WIDTH  = 32;
	localparam int REG_INDEX_WIDTH = APB_ADDR_WIDTH - 2;

	localparam logic [REG_INDEX_WIDTH-1:0] REG_MODE = '0;

	typedef enum logic [1:0] {
		MODE_SUM,
		MODE_COUNT,
		MODE_PRODUCT,
		MODE_MEAN
	} mode_t;

	typedef enum logic [2:0] {
		OP_PASS,
		OP_SUM,
		OP_COUNT,
		OP_MEAN_ACC,
		OP_PROD,
		OP_FILL_TOTAL,
		OP_FILL_COUNT,
		OP_FILL_MEAN
	} op_t;

	typedef struct packed {
		op_t                    op;
		logic [VALUE_WIDTH-1:0] sample;
		logic                   col_end;
	} entry_t;

	typedef struct packed {
		mode_t mode;
		logic  restart;
	} ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_MUL_ADD,
		ST_MUL_DONE,
		ST_DIV,
		ST_FILL
	} back_state_t;

endpackage

// ----- hw/rtl/gfsa_if.sv -----
// ----------------------------------------------------------------------------
// gfsa_if: stream channels of the gap-fill segment aggregator
// Sample channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface gfsa_in_if import gfsa_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] sample_value;
	logic                   is_gap;
	logic                   column_end;

	modport source (output valid, output sample_value, output is_gap, output column_end,
		input ready);
	modport sink (input valid, input sample_value, input is_gap, input column_end,
		output ready);
endinterface

interface gfsa_out_if import gfsa_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] result_value;
	logic                   was_filled;
	logic                   saturated;

	modport source (output valid, output result_value, output was_filled, output saturated,
		input ready);
	modport sink (input valid, input result_value, input was_filled, input saturated,
		output ready);
endinterface

// ----- hw/rtl/gfsa_front.sv -----
// ----------------------------------------------------------------------------
// gfsa_front: sample intake and classification
// Accepts sample beats, turns each into an operation code for the current
// mode and hands it to the queue through one register stage.
// ----------------------------------------------------------------------------
module gfsa_front import gfsa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  mode_t     mode,
	gfsa_in_if.sink   samples,
	output logic      push_valid,
	input  logic      push_ready,
	output entry_t    push_data
);

	logic   valid_s1;
	entry_t entry_s1;
	logic   accept;
	op_t    op;

	assign samples.ready = !valid_s1 || push_ready;
	assign accept        = samples.valid && samples.ready;

	always_comb begin
		op = OP_PASS;
		if (samples.is_gap) begin
			unique case (mode)
				MODE_SUM,
				MODE_PRODUCT: op = OP_FILL_TOTAL;
				MODE_COUNT:   op = OP_FILL_COUNT;
				MODE_MEAN:    op = OP_FILL_MEAN;
				default:      op = OP_FILL_TOTAL;
			endcase
		end else begin
			unique case (mode)
				MODE_SUM:     op = OP_SUM;
				MODE_COUNT:   op = (samples.sample_value != '0) ? OP_COUNT : OP_PASS;
				MODE_PRODUCT: op = OP_PROD;
				MODE_MEAN:    op = OP_MEAN_ACC;
				default:      op = OP_PASS;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !push_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1.op      <= op;
			entry_s1.sample  <= samples.sample_value;
			entry_s1.col_end <= samples.column_end;
		end
	end

	assign push_valid = valid_s1;
	assign push_data  = entry_s1;

endmodule

// ----- hw/rtl/gfsa_queue.sv -----
// ----------------------------------------------------------------------------
// gfsa_queue: short queue between intake and execution
// A small register FIFO that lets either side stall on its own.
// ----------------------------------------------------------------------------
module gfsa_queue import gfsa_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push_valid,
	output logic   push_ready,
	input  entry_t push_data,
	output logic   pop_valid,
	input  logic   pop_ready,
	output entry_t pop_data
);

	localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	entry_t               slots_q [QUEUE_DEPTH];
	logic [PTR_WIDTH-1:0] wr_ptr_q;
	logic [PTR_WIDTH-1:0] rd_ptr_q;
	logic [PTR_WIDTH:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = (count_q != (PTR_WIDTH + 1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- hw/rtl/gfsa_div.sv -----
// ----------------------------------------------------------------------------
// gfsa_div: iterative unsigned divider for the mean fill
// Restoring division, one quotient bit per cycle, quotient ready with done.
// ----------------------------------------------------------------------------
module gfsa_div import gfsa_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [TOTAL_WIDTH-1:0] dividend,
	input  logic [TALLY_WIDTH-1:0] divisor,
	output logic                   done,
	output logic [TOTAL_WIDTH-1:0] quotient
);

	localparam int CNT_WIDTH = $clog2(TOTAL_WIDTH);
	localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(TOTAL_WIDTH - 1);

	logic                   busy_q;
	logic                   done_q;
	logic [CNT_WIDTH-1:0]   cnt_q;
	logic [TALLY_WIDTH-1:0] rem_q;
	logic [TALLY_WIDTH-1:0] dsr_q;
	logic [TOTAL_WIDTH-1:0] quo_q;
	logic [TALLY_WIDTH:0]   trial;
	logic [TALLY_WIDTH:0]   diff;
	logic                   take;

	assign trial = {rem_q, quo_q[TOTAL_WIDTH-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign take  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[TALLY_WIDTH-1:0] : trial[TALLY_WIDTH-1:0];
			quo_q <= {quo_q[TOTAL_WIDTH-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- hw/rtl/gfsa_back.sv -----
// ----------------------------------------------------------------------------
// gfsa_back: aggregate execution and result register
// Carries out queued operations on the running aggregate, runs the product
// over partial products and the mean through the divider, and drives the
// result channel from an output register.
// ----------------------------------------------------------------------------
module gfsa_back import gfsa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ctrl_t     ctrl,
	input  logic      pop_valid,
	output logic      pop_ready,
	input  entry_t    pop_data,
	gfsa_out_if.source results
);

	localparam logic [TOTAL_WIDTH-1:0] TOT_MAX = {1'b0, {(TOTAL_WIDTH - 1){1'b1}}};
	localparam logic [TOTAL_WIDTH-1:0] TOT_MIN = {1'b1, {(TOTAL_WIDTH - 1){1'b0}}};
	localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
	localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};
	localparam logic [TOTAL_WIDTH-1:0] TOT_ONE =
		{{(TOTAL_WIDTH - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [SHIFT_WIDTH-1:0] LIMIT_POS =
		{{(SHIFT_WIDTH - TOTAL_WIDTH){1'b0}}, TOT_MAX};
	localparam logic [SHIFT_WIDTH-1:0] LIMIT_NEG = LIMIT_POS + 1'b1;

	function automatic logic [TOTAL_WIDTH:0] sum_sat(input logic [TOTAL_WIDTH-1:0] a,
		input logic [VALUE_WIDTH-1:0] b);
		logic [TOTAL_WIDTH:0] s;
		s = {a[TOTAL_WIDTH-1], a} + {{(TOTAL_WIDTH + 1 - VALUE_WIDTH){b[VALUE_WIDTH-1]}}, b};
		if (s[TOTAL_WIDTH] != s[TOTAL_WIDTH-1]) begin
			return {1'b1, s[TOTAL_WIDTH] ? TOT_MIN : TOT_MAX};
		end
		return {1'b0, s[TOTAL_WIDTH-1:0]};
	endfunction

	function automatic logic [VALUE_WIDTH:0] clip_value(input logic [TOTAL_WIDTH-1:0] v);
		logic [TOTAL_WIDTH-VALUE_WIDTH:0] hi;
		hi = v[TOTAL_WIDTH-1:VALUE_WIDTH-1];
		if (hi == '0 || hi == '1) begin
			return {1'b0, v[VALUE_WIDTH-1:0]};
		end
		return {1'b1, v[TOTAL_WIDTH-1] ? VAL_MIN : VAL_MAX};
	endfunction

	back_state_t            state_q, state_d;
	logic [TOTAL_WIDTH-1:0] total_q, total_d;
	logic [TALLY_WIDTH-1:0] tally_q, tally_d;
	logic                   ovf_q, ovf_d;
	logic                   col_end_q;
	logic                   neg_q;
	logic [TOTAL_WIDTH-1:0] mag_a_q;
	logic [VALUE_WIDTH-1:0] mag_b_q;
	logic [PROD_WIDTH-1:0]  p_lo_q;
	logic [PROD_WIDTH-1:0]  p_hi_q;
	logic [SHIFT_WIDTH-1:0] prod_q;
	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic                   out_filled_q;
	logic                   out_sat_q;

	logic                   out_free;
	logic                   out_load;
	logic [VALUE_WIDTH-1:0] out_value;
	logic                   out_filled;
	logic                   out_sat;
	logic                   restart;
	logic                   div_start;
	logic                   div_done;
	logic [TOTAL_WIDTH-1:0] quotient;
	logic [TOTAL_WIDTH-1:0] abs_total;
	logic [VALUE_WIDTH-1:0] abs_sample;
	logic [TOTAL_WIDTH:0]   sum_res;
	logic [TALLY_WIDTH-1:0] tally_inc;
	logic                   tally_full;
	logic [TOTAL_WIDTH-1:0] count_agg;
	logic [TOTAL_WIDTH-1:0] mean_agg;
	logic [VALUE_WIDTH:0]   clip_res;
	logic [FULL_WIDTH-1:0]  full_sum;
	logic                   prod_over;
	logic [TOTAL_WIDTH-1:0] prod_res;

	assign abs_total  = total_q[TOTAL_WIDTH-1] ? -total_q : total_q;
	assign abs_sample = pop_data.sample[VALUE_WIDTH-1] ? -pop_data.sample : pop_data.sample;
	assign sum_res    = sum_sat(total_q, pop_data.sample);
	assign tally_inc  = tally_q + 1'b1;
	assign tally_full = (tally_q == '1);
	assign count_agg  =
		{{(TOTAL_WIDTH - TALLY_WIDTH - FRAC_BITS){1'b0}}, tally_q, {FRAC_BITS{1'b0}}};
	assign mean_agg   = neg_q ? -quotient : quotient;
	assign full_sum   = {p_hi_q, {HALF_WIDTH{1'b0}}} + {{HALF_WIDTH{1'b0}}, p_lo_q};
	assign prod_over  = (prod_q > (neg_q ? LIMIT_NEG : LIMIT_POS));
	assign prod_res   = prod_over ? (neg_q ? TOT_MIN : TOT_MAX) :
		(neg_q ? -prod_q[TOTAL_WIDTH-1:0] : prod_q[TOTAL_WIDTH-1:0]);
	assign out_free   = !out_valid_q || results.ready;

	gfsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (abs_total),
		.divisor  (tally_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			total_q <= '0;
			tally_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			total_q <= total_d;
			tally_q <= tally_d;
			ovf_q   <= ovf_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		pop_ready  = 1'b0;
		div_start  = 1'b0;
		out_load   = 1'b0;
		out_value  = pop_data.sample;
		out_filled = 1'b0;
		out_sat    = 1'b0;
		total_d    = total_q;
		tally_d    = tally_q;
		ovf_d      = ovf_q;
		restart    = 1'b0;
		clip_res   = clip_value(total_q);
		unique case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					if (pop_data.op == OP_FILL_MEAN && tally_q != '0) begin
						pop_ready = 1'b1;
						div_start = 1'b1;
						state_d   = ST_DIV;
					end else if (out_free) begin
						pop_ready = 1'b1;
						out_load  = 1'b1;
						restart   = pop_data.col_end;
						case (pop_data.op)
							OP_PASS: begin
							end
							OP_SUM: begin
								total_d = sum_res[TOTAL_WIDTH-1:0];
								ovf_d   = ovf_q || sum_res[TOTAL_WIDTH];
							end
							OP_COUNT: begin
								if (tally_full) begin
									ovf_d = 1'b1;
								end else begin
									tally_d = tally_inc;
								end
							end
							OP_MEAN_ACC: begin
								total_d = sum_res[TOTAL_WIDTH-1:0];
								ovf_d   = ovf_q || sum_res[TOTAL_WIDTH];
								if (!tally_full) begin
									tally_d = tally_inc;
								end
							end
							OP_PROD: begin
								restart = 1'b0;
								state_d = ST_MUL_LO;
							end
							OP_FILL_TOTAL: begin
								out_value  = clip_res[VALUE_WIDTH-1:0];
								out_sat    = ovf_q || clip_res[VALUE_WIDTH];
								out_filled = 1'b1;
								restart    = 1'b1;
							end
							OP_FILL_COUNT: begin
								clip_res   = clip_value(count_agg);
								out_value  = clip_res[VALUE_WIDTH-1:0];
								out_sat    = ovf_q || clip_res[VALUE_WIDTH];
								out_filled = 1'b1;
								restart    = 1'b1;
							end
							OP_FILL_MEAN: begin
								out_value  = '0;
								out_sat    = ovf_q;
								out_filled = 1'b1;
								restart    = 1'b1;
							end
						endcase
					end
				end
			end
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_MUL_ADD;
			ST_MUL_ADD: state_d = ST_MUL_DONE;
			ST_MUL_DONE: begin
				total_d = prod_res;
				ovf_d   = ovf_q || prod_over;
				restart = col_end_q;
				state_d = ST_IDLE;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (out_free) begin
					clip_res   = clip_value(mean_agg);
					out_load   = 1'b1;
					out_value  = clip_res[VALUE_WIDTH-1:0];
					out_sat    = ovf_q || clip_res[VALUE_WIDTH];
					out_filled = 1'b1;
					restart    = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (restart || ctrl.restart) begin
			total_d = (ctrl.mode == MODE_PRODUCT) ? TOT_ONE : '0;
			tally_d = '0;
			ovf_d   = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop_ready) begin
			col_end_q <= pop_data.col_end;
			mag_a_q   <= abs_total;
			mag_b_q   <= abs_sample;
			neg_q     <= (pop_data.op == OP_PROD) ?
				(total_q[TOTAL_WIDTH-1] ^ pop_data.sample[VALUE_WIDTH-1]) :
				total_q[TOTAL_WIDTH-1];
		end
		if (state_q == ST_MUL_LO) begin
			p_lo_q <= PROD_WIDTH'(mag_a_q[HALF_WIDTH-1:0]) * PROD_WIDTH'(mag_b_q);
		end
		if (state_q == ST_MUL_HI) begin
			p_hi_q <= PROD_WIDTH'(mag_a_q[TOTAL_WIDTH-1:HALF_WIDTH]) * PROD_WIDTH'(mag_b_q);
		end
		if (state_q == ST_MUL_ADD) begin
			prod_q <= full_sum[FULL_WIDTH-1:FRAC_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q  <= out_value;
			out_filled_q <= out_filled;
			out_sat_q    <= out_sat;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.result_value = out_value_q;
	assign results.was_filled   = out_filled_q;
	assign results.saturated    = out_sat_q;

endmodule

// ----- hw/rtl/gap_fill_segment_aggregator_core.sv -----
// ----------------------------------------------------------------------------
// gap_fill_segment_aggregator_core: gap-fill segment aggregator
// Replaces gap samples in a column stream with the running aggregate.
// ----------------------------------------------------------------------------
// Samples enter on the samples channel as valid/ready beats; every sample
// gives exactly one beat on the results channel, in order. A sample that is
// not a gap comes back unchanged; a gap comes back as the aggregate (sum,
// nonzero count, product or mean, chosen by the mode register) of the
// samples since the last gap or column end.
// An accepted beat reaches its result beat through the intake register,
// the two-entry queue and the output register.
// Sum, count and pass-through work sustains one beat per cycle while the
// receiver keeps ready high. A product sample holds the execution stage
// through two 24x32 partial products, their add and the saturate. A mean
// fill with samples counted waits on the one-bit-per-cycle divider.
// Reset clears the mode to sum and the aggregate to zero. The mode register
// sits at address 0 of the APB port; writing it restarts the aggregate.
// A stalled receiver fills the output register, then the queue, then the
// intake register, and then the samples channel drops ready; nothing is lost.
// ----------------------------------------------------------------------------
module gap_fill_segment_aggregator_core import gfsa_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_ADDR_WIDTH-1:0] paddr,
	input  logic [APB_DATA_WIDTH-1:0] pwdata,
	output logic [APB_DATA_WIDTH-1:0] prdata,
	output logic                      pready,
	gfsa_in_if.sink                   samples,
	gfsa_out_if.source                results
);

	mode_t                      mode_q;
	logic                       restart_q;
	logic                       cfg_write;
	logic [REG_INDEX_WIDTH-1:0] reg_index;
	ctrl_t                      ctrl;
	logic                       push_valid;
	logic                       push_ready;
	entry_t                     push_data;
	logic                       pop_valid;
	logic                       pop_ready;
	entry_t                     pop_data;

	assign pready    = 1'b1;
	assign reg_index = paddr[APB_ADDR_WIDTH-1:2];
	assign cfg_write = psel && penable && pwrite && (reg_index == REG_MODE);
	assign prdata    = (reg_index == REG_MODE) ?
		{{(APB_DATA_WIDTH - 2){1'b0}}, mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_SUM;
			restart_q <= 1'b0;
		end else begin
			restart_q <= cfg_write;
			if (cfg_write) begin
				mode_q <= mode_t'(pwdata[1:0]);
			end
		end
	end

	assign ctrl.mode    = mode_q;
	assign ctrl.restart = restart_q;

	gfsa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode_q),
		.samples    (samples),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	gfsa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	gfsa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.results   (results)
	);

endmodule

// ----- dv/gap_fill_segment_aggregator_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gap_fill_segment_aggregator_core_tb: self-checking bench of the aggregator
// Streams sample beats with random idle gaps against a stalling receiver.
// The mode register is written between phases, and every result beat is
// compared with the fill arithmetic worked out inside the bench.
// ----------------------------------------------------------------------------
module gap_fill_segment_aggregator_core_tb;
	import gfsa_pkg::*;

	localparam longint TOTAL_MAX    = (longint'(1) << (TOTAL_WIDTH - 1)) - 1;
	localparam longint TOTAL_MIN    = -TOTAL_MAX - 1;
	localparam longint VALUE_MAX    = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
	localparam longint VALUE_MIN    = -VALUE_MAX - 1;
	localparam longint TALLY_MAX    = (longint'(1) << TALLY_WIDTH) - 1;
	localparam longint ONE_Q        = longint'(1) << FRAC_BITS;
	localparam int     MAX_REPORTS  = 10;
	localparam int     DRAIN_CYCLES = 64;
	localparam int     CYCLE_LIMIT  = 2_000_000;
	localparam int     PHASE_ITEMS  = 56;

	localparam logic [REG_INDEX_WIDTH-1:0] REG_SPARE = REG_INDEX_WIDTH'(1);

	typedef struct {
		logic [VALUE_WIDTH-1:0] value;
		logic                   filled;
		logic                   sat;
	} writeback_t;

	class gap_fill_board;
		mode_t      mode;
		longint     total;
		longint     tally;
		bit         overflowed;
		writeback_t awaited_writebacks[$];
		int         mismatches;

		function new();
			mode       = MODE_SUM;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			total      = (mode == MODE_PRODUCT) ? ONE_Q : 0;
			tally      = 0;
			overflowed = 0;
		endfunction

		function void write_reg(logic [REG_INDEX_WIDTH-1:0] index,
			logic [APB_DATA_WIDTH-1:0] data);
			if (index == REG_MODE) begin
				mode = mode_t'(data[1:0]);
				restart();
			end
		endfunction

		function longint add_clipped(longint a, longint b);
			longint s;
			s = a + b;
			if (s > TOTAL_MAX) begin
				overflowed = 1;
				return TOTAL_MAX;
			end
			if (s < TOTAL_MIN) begin
				overflowed = 1;
				return TOTAL_MIN;
			end
			return s;
		endfunction

		function longint multiply_clipped(longint a, longint b);
			logic [79:0] mag_a;
			logic [79:0] mag_b;
			logic [79:0] scaled;
			logic [79:0] limit;
			bit          neg;
			neg    = (a < 0) != (b < 0);
			mag_a  = (a < 0) ? 80'(-a) : 80'(a);
			mag_b  = (b < 0) ? 80'(-b) : 80'(b);
			scaled = (mag_a * mag_b) >> FRAC_BITS;
			limit  = neg ? 80'(TOTAL_MAX) + 80'd1 : 80'(TOTAL_MAX);
			if (scaled > limit) begin
				overflowed = 1;
				return neg ? TOTAL_MIN : TOTAL_MAX;
			end
			return neg ? -longint'(scaled[63:0]) : longint'(scaled[63:0]);
		endfunction

		function void count_one();
			if (tally < TALLY_MAX)
				tally++;
			else if (mode == MODE_COUNT)
				overflowed = 1;
		endfunction

		function void note_sample(logic [VALUE_WIDTH-1:0] raw, logic gap, logic col_end);
			longint     sample;
			longint     fill;
			writeback_t wb;
			sample    = longint'(signed'(raw));
			wb.value  = raw;
			wb.filled = 0;
			wb.sat    = 0;
			if (gap) begin
				case (mode)
					MODE_COUNT: fill = tally << FRAC_BITS;
					MODE_MEAN:  fill = (tally == 0) ? 0 : total / tally;
					default:    fill = total;
				endcase
				wb.sat = overflowed;
				if (fill > VALUE_MAX) begin
					fill   = VALUE_MAX;
					wb.sat = 1;
				end else if (fill < VALUE_MIN) begin
					fill   = VALUE_MIN;
					wb.sat = 1;
				end
				wb.value  = fill[VALUE_WIDTH-1:0];
				wb.filled = 1;
				restart();
			end else begin
				case (mode)
					MODE_SUM:     total = add_clipped(total, sample);
					MODE_COUNT:   if (sample != 0) count_one();
					MODE_PRODUCT: total = multiply_clipped(total, sample);
					MODE_MEAN: begin
						total = add_clipped(total, sample);
						count_one();
					end
				endcase
			end
			if (col_end)
				restart();
			awaited_writebacks.insert(awaited_writebacks.size(), wb);
		endfunction

		function void check_result(logic [VALUE_WIDTH-1:0] value, logic filled, logic sat);
			writeback_t want;
			if (awaited_writebacks.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result beat: value %h filled %b saturated %b",
						value, filled, sat);
				return;
			end
			want = awaited_writebacks.pop_front();
			if (value !== want.value || filled !== want.filled || sat !== want.sat) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result mismatch: expected %h/%b/%b, got %h/%b/%b",
						want.value, want.filled, want.sat, value, filled, sat);
			end
		endfunction

		function int pending();
			return awaited_writebacks.size();
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [APB_ADDR_WIDTH-1:0] paddr;
	logic [APB_DATA_WIDTH-1:0] pwdata;
	logic [APB_DATA_WIDTH-1:0] prdata;
	logic                      pready;

	gfsa_in_if  samples_ch ();
	gfsa_out_if results_ch ();

	gap_fill_board board = new();
	bit            sender_idles = 1;
	bit            receiver_idles = 1;
	int            cycle_count = 0;

	gap_fill_segment_aggregator_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.samples (samples_ch),
		.results (results_ch)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("status: fail");
		$finish;
	end

	function automatic int idle_length();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	initial begin
		int stall;
		stall = 0;
		results_ch.ready = 0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				results_ch.ready = 0;
				stall--;
			end else begin
				results_ch.ready = 1;
				if (receiver_idles && $urandom_range(0, 4) == 0)
					stall = idle_length();
			end
		end
	end

	always @(posedge clk) begin
		if (results_ch.valid === 1'b1 && results_ch.ready === 1'b1)
			board.check_result(results_ch.result_value, results_ch.was_filled,
				results_ch.saturated);
	end

	task automatic hold_samples(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			samples_ch.valid        = 0;
			samples_ch.sample_value = $urandom;
			samples_ch.is_gap       = 1'($urandom_range(0, 1));
			samples_ch.column_end   = 1'($urandom_range(0, 1));
		end
	endtask

	task automatic send_sample(logic [VALUE_WIDTH-1:0] value, logic gap, logic col_end);
		@(negedge clk);
		samples_ch.valid        = 1;
		samples_ch.sample_value = value;
		samples_ch.is_gap       = gap;
		samples_ch.column_end   = col_end;
		do @(posedge clk); while (samples_ch.ready !== 1'b1);
		board.note_sample(value, gap, col_end);
		if (sender_idles && $urandom_range(0, 3) == 0)
			hold_samples(idle_length());
	endtask

	task automatic write_reg(logic [REG_INDEX_WIDTH-1:0] index, logic [APB_DATA_WIDTH-1:0] data);
		@(negedge clk);
		psel    = 1;
		penable = 0;
		pwrite  = 1;
		paddr   = {index, 2'b00};
		pwdata  = data;
		@(negedge clk);
		penable = 1;
		do @(posedge clk); while (pready !== 1'b1);
		board.write_reg(index, data);
		@(negedge clk);
		psel    = 0;
		penable = 0;
		pwrite  = 0;
	endtask

	// The mode register may only change once every result beat is back.
	task automatic settle();
		hold_samples(1);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic change_mode(mode_t m);
		settle();
		write_reg(REG_MODE, ($urandom & ~32'h3) | 32'(m));
	endtask

	function automatic logic [VALUE_WIDTH-1:0] pick_sample(mode_t m);
		logic [VALUE_WIDTH-1:0] edges[6];
		int                     v;
		edges = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000};
		case ($urandom_range(0, 9))
			0, 1:    return edges[$urandom_range(0, 5)];
			2, 3:    return $urandom;
			default: begin
				if (m == MODE_PRODUCT) begin
					v = int'(ONE_Q) + int'($urandom_range(0, 32'h2_0000)) - 32'h1_0000;
					if ($urandom_range(0, 1) == 1)
						v = -v;
				end else begin
					v = int'($urandom_range(0, 32'h10_0000)) - 32'h8_0000;
				end
				return v;
			end
		endcase
	endfunction

	task automatic random_segment(ref int sent);
		int n;
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) begin
			n = $urandom_range(0, 8);
			repeat (n) send_sample(pick_sample(board.mode), 0, 0);
			send_sample($urandom, 1, $urandom_range(0, 3) == 0);
			sent += n + 1;
		end else if (r < 9) begin
			n = $urandom_range(1, 6);
			repeat (n - 1) send_sample(pick_sample(board.mode), 0, 0);
			send_sample(pick_sample(board.mode), 0, 1);
			sent += n;
		end else begin
			send_sample($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			sent += 1;
		end
	endtask

	initial begin
		int sent;
		arst_n                  = 0;
		psel                    = 0;
		penable                 = 0;
		pwrite                  = 0;
		paddr                   = '0;
		pwdata                  = '0;
		samples_ch.valid        = 0;
		samples_ch.sample_value = '0;
		samples_ch.is_gap       = 0;
		samples_ch.column_end   = 0;
		repeat (4) @(negedge clk);
		arst_n = 1;

		// Sum mode straight out of reset.
		send_sample(32'h7FFF_FFFF, 0, 0);
		send_sample(32'h8000_0000, 0, 0);
		send_sample(32'h0, 0, 0);
		send_sample(32'h1, 0, 0);
		send_sample(32'hFFFF_FFFF, 0, 0);
		send_sample(32'hDEAD_BEEF, 1, 0);
		send_sample(32'h1234_5678, 1, 0);
		send_sample(32'h7FFF_FFFF, 0, 0);
		send_sample(32'h7FFF_FFFF, 0, 0);
		send_sample(32'h0, 1, 1);
		send_sample(32'h8000_0000, 0, 0);
		send_sample(32'h8000_0000, 0, 0);
		send_sample(32'h0, 1, 0);
		send_sample(32'h0003_0000, 0, 1);
		send_sample(32'h0, 1, 0);

		change_mode(MODE_COUNT);
		send_sample(32'h0, 0, 0);
		send_sample(32'h5, 0, 0);
		send_sample(32'hFFFD_0000, 0, 0);
		send_sample(32'h0, 0, 0);
		send_sample(32'h0, 1, 0);
		send_sample(32'h7, 0, 0);
		settle();
		// A write to the spare index must leave mode and aggregate alone.
		write_reg(REG_SPARE, 32'(MODE_PRODUCT));
		send_sample(32'h0, 1, 0);

		change_mode(MODE_PRODUCT);
		send_sample(32'h0, 1, 0);
		send_sample(32'h0002_0000, 0, 0);
		send_sample(32'h0003_0000, 0, 0);
		send_sample(32'hFFFF_8000, 0, 0);
		send_sample(32'h0, 1, 0);
		repeat (3) send_sample(32'h7FFF_FFFF, 0, 0);
		send_sample(32'h0, 1, 1);
		repeat (3) send_sample(32'h8000_0000, 0, 0);
		send_sample(32'h0, 1, 0);

		settle();
		write_reg(REG_MODE, 32'hFFFF_FFFF);
		send_sample(32'h0, 1, 0);
		send_sample(32'h0001_0000, 0, 0);
		send_sample(32'h0002_0000, 0, 0);
		send_sample(32'h0004_0000, 0, 0);
		send_sample(32'h0, 1, 0);
		send_sample(32'hFFFF_FFFF, 0, 0);
		send_sample(32'hFFFF_FFFE, 0, 0);
		send_sample(32'h0, 1, 0);
		send_sample(32'h5, 0, 0);
		change_mode(MODE_MEAN);
		send_sample(32'h0, 1, 0);

		for (int phase = 0; phase < 8; phase++) begin
			sender_idles   = (phase % 3) != 2;
			receiver_idles = (phase % 3) != 1;
			change_mode(mode_t'(phase % 4));
			sent = 0;
			while (sent < PHASE_ITEMS)
				random_segment(sent);
		end

		settle();
		if (board.mismatches == 0 && board.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
